[hw/rtl/defc_pkg.sv]
// ----------------------------------------------------------------------------
// defc_pkg
// Shared types and constants for the event frame checker.
// ----------------------------------------------------------------------------
package defc_pkg;

   localparam int FADC_WORDS   = 256;
   localparam int TPC_WORDS    = 512;
   localparam int BUFFER_WORDS = 65536;

   localparam logic [19:0] LOW20     = 20'hfffff;
   localparam logic [31:0] ALL_ONES  = 32'hffffffff;
   localparam logic [12:0] IDX13     = 13'h1fff;
   localparam logic [1:0]  TOP2      = 2'b11;
   localparam logic [27:0] NUM28     = 28'hfffffff;
   localparam logic [19:0] FADC_MARK = 20'h2;
   localparam logic [19:0] TPC_MARK  = 20'h3;
   localparam logic [31:0] HEAD_WORD = 32'h1;
   localparam logic [3:0]  EVNUM_NIB = 4'h4;
   localparam logic [3:0]  CLOCK_NIB = 4'h5;

   localparam logic [3:0] PH_HEAD   = 4'd0;
   localparam logic [3:0] PH_EVNUM  = 4'd1;
   localparam logic [3:0] PH_CLOCK  = 4'd2;
   localparam logic [3:0] PH_MARK1  = 4'd3;
   localparam logic [3:0] PH_FADC   = 4'd4;
   localparam logic [3:0] PH_MARK2  = 4'd5;
   localparam logic [3:0] PH_TPC    = 4'd6;
   localparam logic [3:0] PH_FOOTER = 4'd7;
   localparam logic [3:0] PH_RESYNC = 4'd8;

   localparam logic [7:0] F_HEADER = 8'h01;
   localparam logic [7:0] F_FADC   = 8'h02;
   localparam logic [7:0] F_TPC    = 8'h04;
   localparam logic [7:0] F_LOOSE  = 8'h08;
   localparam logic [7:0] F_DEPTH  = 8'h10;
   localparam logic [7:0] F_FOOTER = 8'h20;
   localparam logic [7:0] F_RESYNC = 8'h40;

   typedef struct packed {
      logic [31:0] data_word;
      logic        end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [27:0] event_number;
      logic [9:0]  event_index;
      logic [15:0] start_offset;
      logic [15:0] length_words;
      logic        header_bad;
      logic        fadc_present;
      logic        tpc_present;
      logic        marker_loose;
      logic        depth_mismatch;
      logic        footer_bad;
      logic        resynced;
      logic        truncated;
   } rsp_type;

endpackage

[hw/rtl/defc_core.sv]
// ----------------------------------------------------------------------------
// defc_core
// Frame state tracking: walks one buffer word per step and builds the
// event record when an event closes or the buffer ends.
// ----------------------------------------------------------------------------
module defc_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  defc_pkg::req_type item,
   output logic              emit,
   output defc_pkg::rsp_type result
);
   import defc_pkg::*;

   logic [3:0]  phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] start_ff, start_in;
   logic [27:0] number_ff, number_in;
   logic [15:0] counter_ff, counter_in;
   logic [7:0]  flags_ff, flags_in;
   logic [9:0]  count_ff, count_in;

   logic [31:0] w;
   logic        last;
   logic        closed;
   logic        tail;
   logic        low20_ones;
   logic [16:0] len_full;
   logic [15:0] len;

   assign w          = item.data_word;
   assign last       = item.end_of_buffer || (pos_ff == 16'(BUFFER_WORDS - 1));
   assign low20_ones = (w[19:0] == LOW20);

   always_comb begin
      phase_in   = phase_ff;
      start_in   = start_ff;
      number_in  = number_ff;
      counter_in = counter_ff;
      flags_in   = flags_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      closed     = 1'b0;
      tail       = 1'b0;

      unique case (phase_ff)
         PH_HEAD: begin
            start_in   = pos_ff;
            number_in  = '0;
            flags_in   = '0;
            counter_in = '0;
            if (w != HEAD_WORD) flags_in = F_HEADER;
            phase_in   = PH_EVNUM;
         end
         PH_EVNUM: begin
            number_in = w[27:0] & NUM28;
            if (w[31:28] != EVNUM_NIB) flags_in = flags_in | F_HEADER;
            phase_in  = PH_CLOCK;
         end
         PH_CLOCK: begin
            if (w[31:28] != CLOCK_NIB) flags_in = flags_in | F_HEADER;
            phase_in = PH_MARK1;
         end
         PH_MARK1: begin
            if (w[19:0] == FADC_MARK) begin
               flags_in = flags_in | F_FADC;
               if (w[31:20] != '0) flags_in = flags_in | F_LOOSE;
               counter_in = '0;
               phase_in   = PH_FADC;
            end else begin
               tail = 1'b1;
            end
         end
         PH_FADC: begin
            counter_in = counter_ff + 16'd1;
            if (counter_in >= 16'(FADC_WORDS)) phase_in = PH_MARK2;
         end
         PH_MARK2: begin
            tail = 1'b1;
         end
         PH_TPC: begin
            if (w[31:30] == TOP2) begin
               if ((w[12:0] & IDX13) != (counter_ff[12:0] & IDX13))
                  flags_in = flags_in | F_DEPTH;
               phase_in = PH_FOOTER;
            end else begin
               counter_in = counter_ff + 16'd1;
               if (counter_in >= 16'(TPC_WORDS)) phase_in = PH_FOOTER;
            end
         end
         PH_FOOTER: begin
            if (w != ALL_ONES) begin
               flags_in = flags_in | F_FOOTER;
               if (!low20_ones) begin
                  flags_in = flags_in | F_RESYNC;
                  phase_in = PH_RESYNC;
               end
            end
            closed = low20_ones;
         end
         default: begin
            phase_in = PH_RESYNC;
            closed   = low20_ones;
         end
      endcase

      if (tail) begin
         if (w[19:0] == TPC_MARK) begin
            flags_in = flags_in | F_TPC;
            if (w[31:20] != '0) flags_in = flags_in | F_LOOSE;
            counter_in = '0;
            phase_in   = PH_TPC;
         end else begin
            if (w != ALL_ONES) begin
               flags_in = flags_in | F_FOOTER;
               if (!low20_ones) begin
                  flags_in = flags_in | F_RESYNC;
                  phase_in = PH_RESYNC;
               end
            end
            closed = low20_ones;
         end
      end

      len_full = {1'b0, pos_ff} - {1'b0, start_in} + 17'd1;
      len      = len_full[16] ? 16'hffff : len_full[15:0];

      result.event_number   = number_in;
      result.event_index    = count_ff;
      result.start_offset   = start_in;
      result.length_words   = len;
      result.header_bad     = (flags_in & F_HEADER) != '0;
      result.fadc_present   = (flags_in & F_FADC) != '0;
      result.tpc_present    = (flags_in & F_TPC) != '0;
      result.marker_loose   = (flags_in & F_LOOSE) != '0;
      result.depth_mismatch = (flags_in & F_DEPTH) != '0;
      result.footer_bad     = (flags_in & F_FOOTER) != '0;
      result.resynced       = (flags_in & F_RESYNC) != '0;
      result.truncated      = !closed;

      emit = step && (closed || last);

      if (closed || last) begin
         count_in   = count_ff + 10'd1;
         phase_in   = PH_HEAD;
         flags_in   = '0;
         counter_in = '0;
      end
      if (last) begin
         pos_in   = '0;
         count_in = '0;
         phase_in = PH_HEAD;
      end else begin
         pos_in = pos_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEAD;
         pos_ff     <= '0;
         start_ff   <= '0;
         number_ff  <= '0;
         counter_ff <= '0;
         flags_ff   <= '0;
         count_ff   <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         start_ff   <= start_in;
         number_ff  <= number_in;
         counter_ff <= counter_in;
         flags_ff   <= flags_in;
         count_ff   <= count_in;
      end
   end

endmodule

[hw/rtl/detector_event_frame_checker.sv]
// ----------------------------------------------------------------------------
// detector_event_frame_checker
// Beats pass the input register, the frame core and the result register.
// Throughput: one word per cycle from the single-pass core unless rsp stalls.
// Input and result registers decouple the two channels.
// Reset is synchronous and returns the frame state to expect a header.
// ----------------------------------------------------------------------------
module detector_event_frame_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  defc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output defc_pkg::rsp_type rsp_data
);
   import defc_pkg::*;

   req_type req_ff;
   logic    req_valid_ff, req_valid_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    advance;
   logic    emit;
   rsp_type result;

   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !req_valid_ff || advance;
   assign req_valid_in = req_ready ? req_valid : req_valid_ff;
   assign rsp_valid_in = advance ? emit : (rsp_valid_ff && !rsp_ready);

   defc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (req_ff),
      .emit   (emit),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      if (advance && emit) rsp_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the detector event frame checker.
// A queue of buffer words feeds a valid/ready driver. Each accepted beat runs
// through a frame predictor that tracks the header, analog, drift, footer and
// resync phases and queues the event record it expects. A monitor compares
// every returned record field by field. The run covers directed frames, then
// random frames and noise under four idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
   import defc_pkg::*;

   typedef enum int {FOOT_GOOD, FOOT_LOOSE, FOOT_RESYNC} footer_kind_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_words[$];
   rsp_type expected_records[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int words_queued   = 0;
   int words_sent     = 0;
   int records_checked = 0;
   int truncated_seen = 0;
   int resync_seen    = 0;
   int error_count    = 0;

   logic [3:0]  frame_phase;
   logic [15:0] word_pos;
   logic [15:0] ev_start;
   logic [15:0] sec_count;
   logic [27:0] ev_number;
   logic [7:0]  ev_flags;
   logic [9:0]  ev_count;

   detector_event_frame_checker DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic bit close_on_footer(input logic [31:0] w);
      if (w == ALL_ONES) return 1'b1;
      ev_flags |= F_FOOTER;
      if (w[19:0] == LOW20) return 1'b1;
      ev_flags |= F_RESYNC;
      frame_phase = PH_RESYNC;
      return 1'b0;
   endfunction

   function automatic bit open_drift_or_footer(input logic [31:0] w);
      if (w[19:0] == TPC_MARK) begin
         ev_flags |= F_TPC;
         if (w != 32'(TPC_MARK)) ev_flags |= F_LOOSE;
         sec_count = '0;
         frame_phase = PH_TPC;
         return 1'b0;
      end
      return close_on_footer(w);
   endfunction

   task automatic predict_frame_word(input req_type beat);
      logic [31:0] w;
      bit          last;
      bit          closed;
      int unsigned span;
      rsp_type     rec;
      w = beat.data_word;
      last = beat.end_of_buffer || (word_pos == 16'(BUFFER_WORDS - 1));
      closed = 1'b0;
      case (frame_phase)
         PH_HEAD: begin
            ev_start = word_pos;
            ev_number = '0;
            ev_flags = '0;
            sec_count = '0;
            if (w != HEAD_WORD) ev_flags |= F_HEADER;
            frame_phase = PH_EVNUM;
         end
         PH_EVNUM: begin
            ev_number = w[27:0];
            if (w[31:28] != EVNUM_NIB) ev_flags |= F_HEADER;
            frame_phase = PH_CLOCK;
         end
         PH_CLOCK: begin
            if (w[31:28] != CLOCK_NIB) ev_flags |= F_HEADER;
            frame_phase = PH_MARK1;
         end
         PH_MARK1: begin
            if (w[19:0] == FADC_MARK) begin
               ev_flags |= F_FADC;
               if (w != 32'(FADC_MARK)) ev_flags |= F_LOOSE;
               sec_count = '0;
               frame_phase = PH_FADC;
            end else begin
               closed = open_drift_or_footer(w);
            end
         end
         PH_FADC: begin
            sec_count = sec_count + 16'd1;
            if (int'(sec_count) >= FADC_WORDS) frame_phase = PH_MARK2;
         end
         PH_MARK2: closed = open_drift_or_footer(w);
         PH_TPC: begin
            if (w[31:30] == TOP2) begin
               if (w[12:0] != sec_count[12:0]) ev_flags |= F_DEPTH;
               frame_phase = PH_FOOTER;
            end else begin
               sec_count = sec_count + 16'd1;
               if (int'(sec_count) >= TPC_WORDS) frame_phase = PH_FOOTER;
            end
         end
         PH_FOOTER: closed = close_on_footer(w);
         default: begin
            frame_phase = PH_RESYNC;
            if (w[19:0] == LOW20) closed = 1'b1;
         end
      endcase

      if (closed || last) begin
         span = int'(word_pos) - int'(ev_start) + 1;
         if (span > 32'hffff) span = 32'hffff;
         rec.event_number   = ev_number;
         rec.event_index    = ev_count;
         rec.start_offset   = ev_start;
         rec.length_words   = span[15:0];
         rec.header_bad     = (ev_flags & F_HEADER) != '0;
         rec.fadc_present   = (ev_flags & F_FADC) != '0;
         rec.tpc_present    = (ev_flags & F_TPC) != '0;
         rec.marker_loose   = (ev_flags & F_LOOSE) != '0;
         rec.depth_mismatch = (ev_flags & F_DEPTH) != '0;
         rec.footer_bad     = (ev_flags & F_FOOTER) != '0;
         rec.resynced       = (ev_flags & F_RESYNC) != '0;
         rec.truncated      = !closed;
         expected_records.push_back(rec);
         ev_count = ev_count + 10'd1;
         frame_phase = PH_HEAD;
         ev_flags = '0;
         sec_count = '0;
      end

      if (last) begin
         word_pos = '0;
         ev_count = '0;
         frame_phase = PH_HEAD;
      end else begin
         word_pos = word_pos + 16'd1;
      end
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      $error("%s: expected %0h, got %0h", field, want, got);
      error_count++;
   endtask

   task automatic check_record(input rsp_type got, input rsp_type want);
      if (got.event_number !== want.event_number)
         report_mismatch("event_number", 32'(want.event_number), 32'(got.event_number));
      if (got.event_index !== want.event_index)
         report_mismatch("event_index", 32'(want.event_index), 32'(got.event_index));
      if (got.start_offset !== want.start_offset)
         report_mismatch("start_offset", 32'(want.start_offset), 32'(got.start_offset));
      if (got.length_words !== want.length_words)
         report_mismatch("length_words", 32'(want.length_words), 32'(got.length_words));
      if (got.header_bad !== want.header_bad)
         report_mismatch("header_bad", 32'(want.header_bad), 32'(got.header_bad));
      if (got.fadc_present !== want.fadc_present)
         report_mismatch("fadc_present", 32'(want.fadc_present), 32'(got.fadc_present));
      if (got.tpc_present !== want.tpc_present)
         report_mismatch("tpc_present", 32'(want.tpc_present), 32'(got.tpc_present));
      if (got.marker_loose !== want.marker_loose)
         report_mismatch("marker_loose", 32'(want.marker_loose), 32'(got.marker_loose));
      if (got.depth_mismatch !== want.depth_mismatch)
         report_mismatch("depth_mismatch", 32'(want.depth_mismatch),
                         32'(got.depth_mismatch));
      if (got.footer_bad !== want.footer_bad)
         report_mismatch("footer_bad", 32'(want.footer_bad), 32'(got.footer_bad));
      if (got.resynced !== want.resynced)
         report_mismatch("resynced", 32'(want.resynced), 32'(got.resynced));
      if (got.truncated !== want.truncated)
         report_mismatch("truncated", 32'(want.truncated), 32'(got.truncated));
   endtask

   // driver: feed buffer words and predict on each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         frame_phase = PH_HEAD;
         word_pos = '0;
         ev_start = '0;
         sec_count = '0;
         ev_number = '0;
         ev_flags = '0;
         ev_count = '0;
      end else begin
         if (req_valid && req_ready) begin
            predict_frame_word(req_data);
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each returned record against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_records.size() == 0) begin
               $error("event record with no expectation pending: %h", rsp_data);
               error_count++;
            end else begin
               if (expected_records[0].truncated) truncated_seen++;
               if (expected_records[0].resynced) resync_seen++;
               check_record(rsp_data, expected_records.pop_front());
               records_checked++;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic push_word(input logic [31:0] word, input bit last = 1'b0);
      req_type beat;
      beat.data_word = word;
      beat.end_of_buffer = last;
      pending_words.push_back(beat);
      words_queued++;
   endtask

   function automatic logic [31:0] non_marker_word();
      logic [31:0] w;
      w = $urandom;
      w[5'($urandom_range(19, 0))] = 1'b0;
      return w;
   endfunction

   function automatic logic [31:0] drift_data_word();
      logic [31:0] w;
      w = $urandom;
      w[5'($urandom_range(31, 30))] = 1'b0;
      return w;
   endfunction

   task automatic push_good_head();
      push_word(HEAD_WORD);
      push_word({EVNUM_NIB, 28'($urandom)});
      push_word({CLOCK_NIB, 28'($urandom)});
   endtask

   task automatic push_event(input bit fadc_on, input bit drift_on, input int drift_words,
                             input bit drift_end_on, input footer_kind_type foot,
                             input bit cut);
      logic [31:0] frame[$];
      int          stop;
      frame.push_back(($urandom_range(9) == 0) ? 32'($urandom) : HEAD_WORD);
      frame.push_back(($urandom_range(9) == 0) ? 32'($urandom) : {EVNUM_NIB, 28'($urandom)});
      frame.push_back(($urandom_range(9) == 0) ? 32'($urandom) : {CLOCK_NIB, 28'($urandom)});
      if (fadc_on) begin
         frame.push_back($urandom_range(1) ? 32'(FADC_MARK)
                                           : {12'($urandom_range(4095, 1)), FADC_MARK});
         repeat (FADC_WORDS) frame.push_back($urandom);
      end
      if (drift_on) begin
         frame.push_back($urandom_range(1) ? 32'(TPC_MARK)
                                           : {12'($urandom_range(4095, 1)), TPC_MARK});
         repeat (drift_words) frame.push_back(drift_data_word());
         if (drift_end_on)
            frame.push_back({TOP2, 17'($urandom),
                             ($urandom_range(4) == 0) ? 13'($urandom) : 13'(drift_words)});
      end
      case (foot)
         FOOT_GOOD: frame.push_back(ALL_ONES);
         FOOT_LOOSE: frame.push_back({12'($urandom_range(4094, 0)), LOW20});
         default: begin
            frame.push_back(non_marker_word());
            repeat ($urandom_range(4)) frame.push_back(non_marker_word());
            frame.push_back({12'($urandom), LOW20});
         end
      endcase
      stop = cut ? $urandom_range(frame.size() - 1) : frame.size() - 1;
      for (int i = 0; i <= stop; i++) push_word(frame[i], cut && i == stop);
   endtask

   task automatic run_random_phase(input int word_goal);
      int              goal_mark;
      int              pick;
      footer_kind_type foot;
      goal_mark = words_queued + word_goal;
      while (words_queued < goal_mark) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            // noise burst, then close the buffer to realign
            repeat ($urandom_range(5)) push_word($urandom);
            push_word($urandom, 1'b1);
         end else begin
            pick = $urandom_range(99);
            foot = (pick < 70) ? FOOT_GOOD : (pick < 85) ? FOOT_LOOSE : FOOT_RESYNC;
            if ($urandom_range(99) < 3)
               push_event($urandom_range(99) < 10, 1'b1, TPC_WORDS, 1'b0, foot,
                          $urandom_range(99) < 8);
            else
               push_event($urandom_range(99) < 10, $urandom_range(99) < 40,
                          $urandom_range(24), 1'b1, foot, $urandom_range(99) < 8);
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || expected_records.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      int send_mix[4];
      int recv_mix[4];
      send_mix = '{0, 74, 0, 20};
      recv_mix = '{0, 0, 74, 20};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_word(HEAD_WORD);
      push_word({EVNUM_NIB, 28'h0});
      push_word({CLOCK_NIB, 28'h0});
      push_word(ALL_ONES);
      push_word(HEAD_WORD);
      push_word({EVNUM_NIB, NUM28});
      push_word({CLOCK_NIB, NUM28});
      push_word(ALL_ONES);
      push_word(ALL_ONES);
      push_word(32'h0fff_ffff);
      push_word(ALL_ONES);
      push_word(32'h000f_ffff);
      push_good_head();
      push_word(32'h8000_0000);
      push_word(32'h0);
      push_word(32'hfff7_ffff);
      push_word(32'h123f_ffff);
      push_word(HEAD_WORD, 1'b1);
      push_word(32'h0);
      push_word({EVNUM_NIB, 28'h5a5a5a5}, 1'b1);
      push_word(HEAD_WORD);
      push_word({EVNUM_NIB, 28'ha5a5a5a});
      push_word({CLOCK_NIB, 28'h1234567}, 1'b1);
      // analog exact, drift loose, matching end index
      push_good_head();
      push_word(32'(FADC_MARK));
      repeat (FADC_WORDS) push_word($urandom);
      push_word({12'hfff, TPC_MARK});
      repeat (3) push_word(drift_data_word());
      push_word({TOP2, 17'h0, 13'd3});
      push_word(ALL_ONES);
      // drift end index mismatch, footer on the last word of the buffer
      push_good_head();
      push_word(32'(TPC_MARK));
      repeat (2) push_word(drift_data_word());
      push_word(ALL_ONES);
      push_word(ALL_ONES, 1'b1);
      // truncate inside resync and inside the analog section
      push_good_head();
      push_word(32'h0);
      push_word(32'h1, 1'b1);
      push_good_head();
      push_word(32'(FADC_MARK));
      repeat (5) push_word($urandom);
      push_word($urandom, 1'b1);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_mix[p];
         recv_stall_pct = recv_mix[p];
         run_random_phase(110);
         wait_drained();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (10) @(negedge clock);
      $display("Streamed %0d buffer words and checked %0d event records across four idle mixes,",
               words_sent, records_checked);
      $display("of which %0d were cut off by a buffer end and %0d needed a resync.",
               truncated_seen, resync_seen);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
